FILE: sv/bss_pkg.sv
// bss_pkg: constants, register codes and helpers for the bounded substring search
// used by the channel interfaces, the match cells and the top level
package bss_pkg;

	localparam int PATTERN_MAX = 8;
	localparam int INDEX_BITS  = 16;

	// pattern register holds at most eight characters
	localparam int PAT_CHARS = 8;
	localparam int CELLS     = (PATTERN_MAX < PAT_CHARS) ? PATTERN_MAX : PAT_CHARS;
	localparam int LEN_W     = $clog2(CELLS + 1);
	localparam int HIT_W     = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int POS_W     = INDEX_BITS + 1;

	localparam int PAT_W     = 8 * PAT_CHARS;
	localparam int PLEN_W    = 4;
	localparam int LIMIT_W   = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [POS_W-1:0] POS_SAT = {POS_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_BYTES  = 2'd0,
		CFG_PATTERN_LENGTH = 2'd1,
		CFG_SEARCH_LIMIT   = 2'd2
	} cfg_reg_t;

	// per-byte control broadcast to the cell row
	typedef struct packed {
		logic en;
	} bss_step_t;

	// pattern length in use: saturated, cut short at the first zero character
	function automatic logic [LEN_W-1:0] eff_len(input logic [PAT_W-1:0] pat,
	                                             input logic [PLEN_W-1:0] plen);
		logic [LEN_W-1:0] n;
		logic             stop;
		n    = (int'(plen) > CELLS) ? LEN_W'(CELLS) : LEN_W'(plen);
		stop = 1'b0;
		for (int k = 0; k < CELLS; k++) begin
			if (!stop && (LEN_W'(k) < n) && (pat[8*k +: 8] == 8'h00)) begin
				n    = LEN_W'(k);
				stop = 1'b1;
			end
		end
		return n;
	endfunction

endpackage

FILE: sv/bss_if.sv
// bss channel interfaces: text input, result output and configuration write
// depends on bss_pkg for field widths
interface bss_text_if import bss_pkg::*;;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       start_of_text;
	logic       end_of_text;

	modport source (output valid, text_byte, start_of_text, end_of_text, input ready);
	modport sink   (input valid, text_byte, start_of_text, end_of_text, output ready);
endinterface

interface bss_result_if import bss_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic                  match_found;
	logic [INDEX_BITS-1:0] match_index;

	modport source (output valid, match_found, match_index, input ready);
	modport sink   (input valid, match_found, match_index, output ready);
endinterface

interface bss_cfg_if import bss_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [PAT_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/bss_cell.sv
// bss_cell: one partial-match cell of the search row
// depends on bss_pkg for the step control struct
module bss_cell import bss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  bss_step_t  ctl,
	input  logic       chain_in,
	input  logic [7:0] text_byte,
	input  logic [7:0] pat_char,
	output logic       chain_out,
	output logic       hit
);

	logic match_q;

	// prefix up to this character ends on the current byte
	assign hit       = chain_in && (text_byte == pat_char);
	assign chain_out = match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.en) begin
			match_q <= hit;
		end
	end

endmodule

FILE: sv/bounded_substring_search_top.sv
// bounded_substring_search_top: streaming bounded substring search, top level
// depends on bss_pkg, bss_if (channel interfaces) and bss_cell
// a result is registered in the output register, or in the skid stage while it is full
// throughput: one text byte per cycle, one cell row step each, while skid is empty
// a two-entry output (register plus skid) lets bytes keep flowing while a result waits
// reset: config registers zero, cells cleared, search idle until a start_of_text byte
module bounded_substring_search_top import bss_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	bss_text_if.sink            text,
	bss_result_if.source        result,
	bss_cfg_if.sink             cfg
);

	// configuration registers
	logic [PAT_W-1:0]   pattern_q;
	logic [PLEN_W-1:0]  length_q;
	logic [LIMIT_W-1:0] limit_q;

	// search state
	logic [POS_W-1:0]   pos_q;
	logic               done_q;

	// output register and skid stage
	logic                  out_v_q;
	logic                  out_found_q;
	logic [INDEX_BITS-1:0] out_idx_q;
	logic                  skid_v_q;
	logic                  skid_found_q;
	logic [INDEX_BITS-1:0] skid_idx_q;

	// cell row
	logic [CELLS-1:0] link;
	logic [CELLS-1:0] cell_q;
	logic [CELLS-1:0] hit;
	bss_step_t        step;

	// per-byte decision
	logic                  fire;
	logic                  done_eff;
	logic [POS_W-1:0]      pos_eff;
	logic [LEN_W-1:0]      len;
	logic [HIT_W-1:0]      hit_sel;
	logic                  res_v;
	logic                  res_found;
	logic [INDEX_BITS-1:0] res_idx;
	logic                  done_d;
	logic [POS_W-1:0]      pos_d;
	logic                  out_free;

	// configuration port is always ready; unknown indexes are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			length_q  <= '0;
			limit_q   <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_PATTERN_BYTES:  pattern_q <= cfg.data;
				CFG_PATTERN_LENGTH: length_q  <= cfg.data[PLEN_W-1:0];
				CFG_SEARCH_LIMIT:   limit_q   <= cfg.data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// a new byte is taken whenever the skid stage is empty
	assign text.ready = !skid_v_q;
	assign fire       = text.valid && text.ready;

	// start of text clears the search before the byte is handled
	assign done_eff = text.start_of_text ? 1'b0 : done_q;
	assign pos_eff  = text.start_of_text ? '0 : pos_q;

	assign len     = eff_len(pattern_q, length_q);
	assign hit_sel = HIT_W'(len - LEN_W'(1));

	// first cell always starts a prefix, the others continue their neighbour's,
	// except on a new text where earlier prefixes are dropped
	always_comb begin
		link[0] = 1'b1;
		for (int k = 1; k < CELLS; k++) begin
			link[k] = cell_q[k-1] && !text.start_of_text;
		end
	end

	genvar g;
	generate
		for (g = 0; g < CELLS; g++) begin : g_cell
			bss_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (step),
				.chain_in  (link[g]),
				.text_byte (text.text_byte),
				.pat_char  (pattern_q[8*g +: 8]),
				.chain_out (cell_q[g]),
				.hit       (hit[g])
			);
		end
	endgenerate

	// decision for the byte on the input channel
	always_comb begin
		step.en   = 1'b0;
		res_v     = 1'b0;
		res_found = 1'b0;
		res_idx   = '0;
		pos_d     = pos_eff;
		if (fire && !done_eff) begin
			if (len == '0) begin
				// empty pattern: found at the very first byte
				res_v     = 1'b1;
				res_found = 1'b1;
			end else if ((text.text_byte == 8'h00) || (pos_eff >= POS_W'(limit_q))) begin
				// zero byte or limit already reached
				res_v = 1'b1;
			end else begin
				step.en = 1'b1;
				pos_d   = (pos_eff == POS_SAT) ? pos_eff : pos_eff + POS_W'(1);
				if (hit[hit_sel]) begin
					res_v     = 1'b1;
					res_found = 1'b1;
					res_idx   = INDEX_BITS'(pos_eff + POS_W'(1) - POS_W'(len));
				end else if (text.end_of_text ||
				             ((pos_eff + POS_W'(1)) >= POS_W'(limit_q))) begin
					// last byte of the text or of the window, no match
					res_v = 1'b1;
				end
			end
		end
	end

	assign done_d = done_eff || res_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b1;
			pos_q  <= '0;
		end else if (fire) begin
			done_q <= done_d;
			pos_q  <= pos_d;
		end
	end

	// output register with skid: skid holds a result only while the register is full
	assign out_free = !out_v_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (skid_v_q) begin
				if (out_free) begin
					out_v_q  <= 1'b1;
					skid_v_q <= 1'b0;
				end
			end else if (res_v) begin
				if (out_free) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_free) begin
				out_found_q <= skid_found_q;
				out_idx_q   <= skid_idx_q;
			end
		end else if (res_v) begin
			if (out_free) begin
				out_found_q <= res_found;
				out_idx_q   <= res_idx;
			end else begin
				skid_found_q <= res_found;
				skid_idx_q   <= res_idx;
			end
		end
	end

	assign result.valid       = out_v_q;
	assign result.match_found = out_found_q;
	assign result.match_index = out_idx_q;

	// skid stage is only ever filled behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid stage holds a result while the output register is empty");

	// a reported result always closes the search
	a_result_closes: assert property (@(posedge clk) disable iff (!arst_n)
		res_v |=> done_q)
		else $error("search still open after a result");

	// a not-found transaction carries index zero
	a_miss_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.match_found) |-> (result.match_index == '0))
		else $error("not-found result with non-zero index");

	// bytes of a closed search leave the output side untouched
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && done_q && !text.start_of_text) |-> !res_v)
		else $error("result raised while the search is closed");

endmodule
